// ===== rtl/mpq_pkg.sv =====
// Shared types and constants for the min priority queue with search.
// Used by mpq_ctrl, mpq_dp, min_priority_queue_with_search_unit and the testbench.
`default_nettype none

package mpq_pkg;

   // Widths of the payload fields
   localparam int DATA_WIDTH   = 32;
   localparam int MODE_WIDTH   = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int ECOUNT_WIDTH = 5;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_WIDTH = 40;
   localparam int RSP_WIDTH = 40;

   // Default number of stored values
   localparam int CAPACITY_DEFAULT = 16;

   // Operation codes; the fourth code is a no-op
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_SEARCH = 2'd2
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Write data / address select for the store
   typedef enum logic [1:0] {
      WR_VALUE = 2'd0,   // request value at idx
      WR_UP    = 2'd1,   // read data at idx (shift toward the tail)
      WR_DOWN  = 2'd2    // read data at idx-1 (shift toward the head)
   } wr_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;          // capture request, init index and status
      logic       rd_en;         // issue a store read
      logic       rd_prev;       // read at idx-1 instead of idx
      logic       wr_en;         // write the store
      wr_sel_type wr_sel;
      logic       idx_inc;
      logic       idx_dec;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       min_from_val;
      logic       min_from_rdata;
      logic       found_set;
      logic       rsp_load;      // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic     [MODE_WIDTH-1:0] op;
      logic     full;
      logic     empty;
      logic     idx_zero;
      logic     idx_one;
      logic     idx_at_count;
      logic     greater;         // read data > request value (signed)
      logic     equal;           // read data == request value
      logic     rsp_free;        // result register can take a new result
   } stat_type;

endpackage : mpq_pkg

`default_nettype wire

// ===== rtl/mpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : mpq_ram

`default_nettype wire

// ===== rtl/mpq_ctrl.sv =====
// Sequencing state machine for the priority queue: scans the sorted store
// one entry per read/compare pair. Depends on mpq_pkg.
`default_nettype none

module mpq_ctrl
   import mpq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic [MODE_WIDTH-1:0] req_mode,
   output logic                      req_tready,
   input  wire stat_type              stat,
   output cmd_type                   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wr_sel = WR_VALUE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               priority if (req_mode == MODE_INSERT && !stat.full) begin
                  state_in = ST_READ;
               end else if (req_mode == MODE_DELETE && !stat.empty) begin
                  state_in = ST_READ;
               end else if (req_mode == MODE_SEARCH) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            unique case (stat.op)
               MODE_INSERT: begin
                  if (stat.idx_zero) begin
                     // reached the head: new minimum
                     cmd.wr_en        = 1'b1;
                     cmd.wr_sel       = WR_VALUE;
                     cmd.min_from_val = 1'b1;
                     cmd.cnt_inc      = 1'b1;
                     state_in         = ST_DONE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_prev = 1'b1;
                     state_in    = ST_CMP;
                  end
               end
               MODE_DELETE: begin
                  if (stat.idx_at_count) begin
                     cmd.cnt_dec = 1'b1;
                     state_in    = ST_DONE;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_CMP;
                  end
               end
               MODE_SEARCH: begin
                  if (stat.idx_at_count) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.rd_en = 1'b1;
                     state_in  = ST_CMP;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CMP: begin
            unique case (stat.op)
               MODE_INSERT: begin
                  cmd.wr_en = 1'b1;
                  if (stat.greater) begin
                     cmd.wr_sel  = WR_UP;
                     cmd.idx_dec = 1'b1;
                     state_in    = ST_READ;
                  end else begin
                     // equal values stay ahead of the new one
                     cmd.wr_sel  = WR_VALUE;
                     cmd.cnt_inc = 1'b1;
                     state_in    = ST_DONE;
                  end
               end
               MODE_DELETE: begin
                  cmd.wr_en          = 1'b1;
                  cmd.wr_sel         = WR_DOWN;
                  cmd.min_from_rdata = stat.idx_one;
                  cmd.idx_inc        = 1'b1;
                  state_in           = ST_READ;
               end
               MODE_SEARCH: begin
                  if (stat.equal) begin
                     cmd.found_set = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : mpq_ctrl

`default_nettype wire

// ===== rtl/mpq_dp.sv =====
// Datapath of the priority queue: sorted store, scan index, count, minimum
// and the result register. Depends on mpq_pkg and mpq_ram.
`default_nettype none

module mpq_dp
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [REQ_WIDTH-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [RSP_WIDTH-1:0] rsp_tdata,
   input  wire cmd_type              cmd,
   output stat_type                 stat
);

   localparam int CntWidth  = $clog2(CAPACITY + 1);
   localparam int AddrWidth = $clog2(CAPACITY);

   // request fields
   logic [MODE_WIDTH-1:0] req_mode;
   logic [DATA_WIDTH-1:0] req_value;
   assign req_mode  = req_tdata[MODE_WIDTH-1:0];
   assign req_value = req_tdata[MODE_WIDTH+DATA_WIDTH-1:MODE_WIDTH];

   logic [MODE_WIDTH-1:0]   op_ff;
   logic [DATA_WIDTH-1:0]   val_ff;
   logic [CntWidth-1:0]     idx_ff, idx_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]   min_ff, min_in;
   logic                    found_ff, found_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]    rsp_data_ff;

   logic [CntWidth-1:0]     idx_m1;
   logic                    full;
   logic                    empty;
   logic [DATA_WIDTH-1:0]   rd_data;
   logic [AddrWidth-1:0]    rd_addr;
   logic [AddrWidth-1:0]    wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic [CntWidth+ECOUNT_WIDTH-1:0] cnt_wide;
   logic [DATA_WIDTH-1:0]   min_out;

   assign idx_m1 = idx_ff - CntWidth'(1);
   assign full   = (cnt_ff == CntWidth'(CAPACITY));
   assign empty  = (cnt_ff == '0);

   // store addressing
   assign rd_addr = cmd.rd_prev ? idx_m1[AddrWidth-1:0] : idx_ff[AddrWidth-1:0];
   assign wr_addr = (cmd.wr_sel == WR_DOWN) ? idx_m1[AddrWidth-1:0]
                                            : idx_ff[AddrWidth-1:0];
   assign wr_data = (cmd.wr_sel == WR_VALUE) ? val_ff : rd_data;

   mpq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // status to controller
   assign stat.op           = op_ff;
   assign stat.full         = full;
   assign stat.empty        = empty;
   assign stat.idx_zero     = (idx_ff == '0);
   assign stat.idx_one      = (idx_ff == CntWidth'(1));
   assign stat.idx_at_count = (idx_ff == cnt_ff);
   assign stat.greater      = ($signed(rd_data) > $signed(val_ff));
   assign stat.equal        = (rd_data == val_ff);
   assign stat.rsp_free     = !rsp_valid_ff || rsp_tready;

   // index, count, minimum, found and status updates
   always_comb begin
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      min_in    = min_ff;
      found_in  = found_ff;
      status_in = status_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         priority if (req_mode == MODE_INSERT) begin
            idx_in    = cnt_ff;
            status_in = full ? STATUS_FULL : STATUS_OK;
         end else if (req_mode == MODE_DELETE) begin
            idx_in    = CntWidth'(1);
            status_in = empty ? STATUS_EMPTY : STATUS_OK;
         end else begin
            idx_in    = '0;
            status_in = STATUS_OK;
         end
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CntWidth'(1);
      end
      if (cmd.idx_dec) begin
         idx_in = idx_m1;
      end
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end
      if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
      if (cmd.min_from_val) begin
         min_in = val_ff;
      end
      if (cmd.min_from_rdata) begin
         min_in = rd_data;
      end
      if (cmd.found_set) begin
         found_in = 1'b1;
      end
   end

   // result fields
   assign cnt_wide = (CntWidth+ECOUNT_WIDTH)'(cnt_ff);
   assign min_out  = empty ? '0 : min_ff;

   // result handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_mode;
         val_ff <= req_value;
      end
      idx_ff    <= idx_in;
      min_ff    <= min_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= {min_out, cnt_wide[ECOUNT_WIDTH-1:0], status_ff, found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : mpq_dp

`default_nettype wire

// ===== rtl/min_priority_queue_with_search_unit.sv =====
// Min priority queue with search: top level joining controller and datapath.
// One request at a time: req_tready is high only in the idle state, and a request is held off
// until the result of the last one is loaded into the result register, which waits while an
// untaken result is held there. rsp_tvalid rises in the same cycle that req_tready returns. A
// no-op, dropped insert or empty delete skips the store scan; the others scan one entry per
// read and compare state pair. Reset clears state, count and result valid. Uses mpq_ctrl, mpq_dp.
`default_nettype none

module min_priority_queue_with_search_unit
   import mpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                     req_tready,
   input  wire logic [REQ_WIDTH-1:0] req_tdata,   // mode[1:0], value[33:2], zero pad
   output logic                     rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [RSP_WIDTH-1:0] rsp_tdata    // found[0], status[2:1],
                                                  // entry_count[7:3], min_value[39:8]
);

   cmd_type  cmd;
   stat_type stat;

   mpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tdata[MODE_WIDTH-1:0]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   // never grow past capacity or shrink below empty
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !stat.full)
      else $error("count increment while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> !stat.empty)
      else $error("count decrement while empty");

   // a result is only loaded when the output register is free
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("result overwritten before taken");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

endmodule : min_priority_queue_with_search_unit

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for min_priority_queue_with_search_unit.
// Streams insert, delete-min, search and no-op requests into the queue and compares every
// result with a local sorted-list predictor. Depends on mpq_pkg and the unit's RTL.
`default_nettype none

module testbench;
   import mpq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 800000;
   localparam int RANDOM_REQUESTS = 1800;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;

   // Unused fourth operation code: the queue leaves its contents alone
   localparam logic [MODE_WIDTH-1:0] MODE_NOOP = 2'd3;

   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [DATA_WIDTH-1:0] value;
   } op_request_t;

   // Queue state as reported by one result
   typedef struct packed {
      logic                    found;
      status_type              status;
      logic [ECOUNT_WIDTH-1:0] entry_count;
      logic [DATA_WIDTH-1:0]   min_value;
   } queue_view_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;   // mode[1:0], value[33:2], zero pad
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;        // found[0], status[2:1],
                                           // entry_count[7:3], min_value[39:8]

   min_priority_queue_with_search_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Predictor state: values held in ascending order
   logic signed [DATA_WIDTH-1:0] held_values[$];
   op_request_t                  pending_requests[$];
   queue_view_t                  expected_views[$];

   int total_requests = 0;
   int requests_accepted = 0;
   int results_checked = 0;
   int error_count = 0;
   int cycle_count = 0;

   // Coverage tallies for the summary
   int n_insert = 0, n_full = 0, n_delete = 0, n_empty = 0;
   int n_search = 0, n_hits = 0, n_noop = 0, n_at_capacity = 0;

   // Sender and receiver pacing
   int gap_left = 0, burst_left = 0;
   int stall_kind = 0, stall_left = 0, hold_left = 0, holds_taken = 0;

   // Stimulus generation
   logic [DATA_WIDTH-1:0] value_pool[8];
   int                    planned_count = 0;

   // Apply one request to the predictor and return the queue view it causes
   function automatic queue_view_t apply_request(logic [MODE_WIDTH-1:0] mode,
                                                 logic signed [DATA_WIDTH-1:0] value);
      queue_view_t view;
      int          pos;
      view.found  = 1'b0;
      view.status = STATUS_OK;
      case (mode)
         MODE_INSERT: begin
            n_insert++;
            if (held_values.size() >= CAPACITY) begin
               view.status = STATUS_FULL;
               n_full++;
            end else begin
               // New value goes behind equal values already held
               pos = held_values.size();
               while (pos > 0 && held_values[pos-1] > value)
                  pos--;
               held_values.insert(pos, value);
               if (held_values.size() == CAPACITY)
                  n_at_capacity++;
            end
         end
         MODE_DELETE: begin
            n_delete++;
            if (held_values.size() == 0) begin
               view.status = STATUS_EMPTY;
               n_empty++;
            end else begin
               void'(held_values.pop_front());
            end
         end
         MODE_SEARCH: begin
            n_search++;
            foreach (held_values[i])
               if (held_values[i] == value)
                  view.found = 1'b1;
            if (view.found)
               n_hits++;
         end
         default: n_noop++;
      endcase
      view.entry_count = ECOUNT_WIDTH'(held_values.size());
      view.min_value   = (held_values.size() != 0) ? held_values[0] : '0;
      return view;
   endfunction

   task automatic queue_request(logic [MODE_WIDTH-1:0] mode, logic [DATA_WIDTH-1:0] value);
      op_request_t item;
      item.mode  = mode;
      item.value = value;
      pending_requests.push_back(item);
      total_requests++;
      // Track the count the generator expects, to steer fill and drain phases
      if (mode == MODE_INSERT && planned_count < CAPACITY)
         planned_count++;
      else if (mode == MODE_DELETE && planned_count > 0)
         planned_count--;
   endtask

   // Mostly a small pool so searches hit and duplicates form, plus corners and noise
   function automatic logic [DATA_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return value_pool[$urandom_range(0, 7)];
      if (roll < 60) begin
         case ($urandom_range(0, 3))
            0:       return MOST_NEGATIVE;
            1:       return MOST_POSITIVE;
            2:       return '0;
            default: return ALL_ONES;
         endcase
      end
      return $urandom;
   endfunction

   task automatic compare_field(string name, logic [DATA_WIDTH-1:0] want,
                                logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: offers pending requests in bursts and predicts each accepted one
   always @(posedge clock) begin
      op_request_t next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_views.push_back(apply_request(req_tdata[1:0], req_tdata[33:2]));
            requests_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_WIDTH - MODE_WIDTH - DATA_WIDTH){1'b0}},
                              next_req.value, next_req.mode};
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  case ($urandom_range(0, 4))
                     0, 1:    gap_left = 0;
                     2, 3:    gap_left = $urandom_range(1, 3);
                     default: gap_left = $urandom_range(4, 20);
                  endcase
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern of its own, with two long hold-offs to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_taken < 2 && results_checked >= (holds_taken + 1) * 600) begin
            hold_left = 400;
            holds_taken++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (stall_left == 0) begin
               stall_kind = $urandom_range(0, 3);
               stall_left = $urandom_range(10, 120);
            end
            stall_left--;
            case (stall_kind)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // Monitor: checks every accepted result against the oldest expectation
   always @(posedge clock) begin
      queue_view_t seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.found       = rsp_tdata[0];
         seen.status      = status_type'(rsp_tdata[2:1]);
         seen.entry_count = rsp_tdata[7:3];
         seen.min_value   = rsp_tdata[39:8];
         if (expected_views.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing expected, actual %0h", $time, rsp_tdata);
         end else begin
            want = expected_views.pop_front();
            compare_field("found", want.found, seen.found);
            compare_field("status", want.status, seen.status);
            compare_field("entry_count", want.entry_count, seen.entry_count);
            compare_field("min_value", want.min_value, seen.min_value);
         end
         results_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d requests accepted, %0d results pending",
                  $time, requests_accepted, total_requests, expected_views.size());
         $display("** min_priority_queue_with_search_unit: FAILED **");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int target, roll;
      logic [MODE_WIDTH-1:0] op;

      for (int i = 0; i < 4; i++)
         value_pool[i] = $urandom;
      for (int i = 4; i < 8; i++)
         value_pool[i] = $urandom_range(0, 6) - 3;

      // Directed: empty queue corner cases
      queue_request(MODE_DELETE, $urandom);
      queue_request(MODE_SEARCH, '0);
      queue_request(MODE_NOOP, ALL_ONES);
      // Fill to capacity with extremes and duplicates
      queue_request(MODE_INSERT, MOST_POSITIVE);
      queue_request(MODE_INSERT, MOST_NEGATIVE);
      queue_request(MODE_INSERT, '0);
      queue_request(MODE_INSERT, ALL_ONES);
      queue_request(MODE_INSERT, 32'd1);
      queue_request(MODE_INSERT, 32'd5);
      queue_request(MODE_INSERT, 32'd5);
      queue_request(MODE_INSERT, -32'sd5);
      queue_request(MODE_INSERT, MOST_POSITIVE);
      queue_request(MODE_INSERT, MOST_NEGATIVE);
      queue_request(MODE_INSERT, 32'd100);
      queue_request(MODE_INSERT, -32'sd100);
      queue_request(MODE_INSERT, 32'h4000_0000);
      queue_request(MODE_INSERT, 32'hC000_0000);
      queue_request(MODE_INSERT, 32'd7);
      queue_request(MODE_INSERT, 32'd3);
      // Full queue: dropped insert, hit and miss, no-op, then pop the minimum
      queue_request(MODE_INSERT, 32'd42);
      queue_request(MODE_SEARCH, MOST_POSITIVE);
      queue_request(MODE_SEARCH, 32'd42);
      queue_request(MODE_NOOP, 32'd42);
      queue_request(MODE_DELETE, $urandom);
      queue_request(MODE_SEARCH, MOST_NEGATIVE);

      // Random: walk the count toward changing targets, including empty and full
      target = CAPACITY;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (planned_count == target) begin
            case ($urandom_range(0, 3))
               0:       target = 0;
               1:       target = CAPACITY;
               default: target = $urandom_range(0, CAPACITY);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 6)
            op = MODE_NOOP;
         else if (roll < 26)
            op = MODE_SEARCH;
         else if (planned_count < target)
            op = ($urandom_range(0, 4) != 0) ? MODE_INSERT : MODE_DELETE;
         else if (planned_count > target)
            op = ($urandom_range(0, 4) != 0) ? MODE_DELETE : MODE_INSERT;
         else
            op = $urandom_range(0, 1) ? MODE_INSERT : MODE_DELETE;
         queue_request(op, (op == MODE_DELETE || op == MODE_NOOP) ? $urandom : pick_value());
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (requests_accepted == total_requests);
      while (expected_views.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d inserts (%0d dropped when full, %0d fills), "
               , total_requests, n_insert, n_full, n_at_capacity);
      $display("%0d deletes (%0d on empty), %0d searches (%0d hits), %0d no-ops; %0d errors",
               n_delete, n_empty, n_search, n_hits, n_noop, error_count);
      if (error_count == 0 && expected_views.size() == 0) begin
         $display("** min_priority_queue_with_search_unit: PASSED **");
      end else begin
         $display("** min_priority_queue_with_search_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
